// ===== hdl/mts_pkg.sv =====
package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 7;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // s side: tuser = opcode, tdata = push_value
    localparam int S_TUSER_W = 1;
    localparam int S_TDATA_W = DATA_W;
    // m side: tdata = popped, top, min, depth, is_empty; tuser = status
    localparam int M_TDATA_W = 3 * DATA_W + DEPTH_W + 1;
    localparam int M_TUSER_W = 2;

    typedef enum logic [S_TUSER_W-1:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [M_TUSER_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // packed so that popped_value lands in the low bits of tdata
    typedef struct packed {
        logic                      is_empty;
        logic [DEPTH_W-1:0]        depth;
        logic signed [DATA_W-1:0]  min_value;
        logic signed [DATA_W-1:0]  top_value;
        logic signed [DATA_W-1:0]  popped_value;
    } t_result;

endpackage

// ===== hdl/mts_ram.sv =====
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/min_tracking_stack_unit.sv =====
// Min-tracking LIFO stack: push/pop of signed 32-bit values, reports min.
// The result beat is registered, offered in the cycle after its input beat.
// Throughput: one beat per cycle unless the output stalls; the two top
// entries of each stack sit in flops; RAMs prefetch the third; pops never wait.
// Reset (i_rst_n low, synchronous): both stacks empty, output not valid.
// Stored entries are not cleared; only entries below the counts are read.
module min_tracking_stack_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] push_value
    input  logic [mts_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] opcode
    input  logic [mts_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] popped_value, [63:32] top_value, [95:64] min_value,
    // [102:96] depth, [103] is_empty
    output logic [mts_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // [1:0] status
    output logic [mts_pkg::M_TUSER_W-1:0]   o_m_axis_tuser
);

    import mts_pkg::*;

    // counts and cached top-of-stack entries
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_mcount, n_mcount;
    logic signed [DATA_W-1:0] r_top0, n_top0;   // value_store[count-1]
    logic signed [DATA_W-1:0] r_top1, n_top1;   // value_store[count-2]
    logic signed [DATA_W-1:0] r_min0, n_min0;   // minimum_store[mcount-1]
    logic signed [DATA_W-1:0] r_min1, n_min1;   // minimum_store[mcount-2]

    // output register
    logic                     r_out_valid;
    t_result                  r_res, n_res;
    t_status                  r_status, n_status;

    // RAM side: entries below the cached pair come back in the cycle after the
    // read address, which is always derived from the next count
    logic                     w_accept;
    logic signed [DATA_W-1:0] w_push_value;
    logic                     w_val_wr, w_min_wr;
    logic [ADDR_W-1:0]        w_val_wr_addr, w_min_wr_addr;
    logic [ADDR_W-1:0]        w_val_rd_addr, w_min_rd_addr;
    logic [DATA_W-1:0]        w_val_rd_data, w_min_rd_data;

    assign w_push_value    = i_s_axis_tdata;
    // take a new beat when the result slot is free or draining this cycle
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_count       = r_count;
        n_mcount      = r_mcount;
        n_top0        = r_top0;
        n_top1        = r_top1;
        n_min0        = r_min0;
        n_min1        = r_min1;
        n_status      = ST_OK;
        w_val_wr      = 1'b0;
        w_min_wr      = 1'b0;
        w_val_wr_addr = r_count[ADDR_W-1:0];
        w_min_wr_addr = r_mcount[ADDR_W-1:0];
        n_res.popped_value = '0;

        if (w_accept) begin
            unique case (t_opcode'(i_s_axis_tuser))
                OP_PUSH: begin
                    if (r_count == CNT_W'(STACK_DEPTH)) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        w_val_wr = 1'b1;
                        n_count  = r_count + 1'b1;
                        n_top1   = r_top0;
                        n_top0   = w_push_value;
                        if (r_mcount == '0) begin
                            w_min_wr = 1'b1;
                            n_mcount = CNT_W'(1);
                            n_min0   = w_push_value;
                        end else if (r_mcount < CNT_W'(STACK_DEPTH)
                                     && r_min0 >= w_push_value) begin
                            w_min_wr = 1'b1;
                            n_mcount = r_mcount + 1'b1;
                            n_min1   = r_min0;
                            n_min0   = w_push_value;
                        end
                    end
                end
                OP_POP: begin
                    if (r_count == '0) begin
                        n_status           = ST_UNDERFLOW;
                        n_res.popped_value = -32'sd1;
                    end else begin
                        n_res.popped_value = r_top0;
                        n_count = r_count - 1'b1;
                        n_top0  = r_top1;
                        n_top1  = w_val_rd_data;
                        if (r_mcount != '0 && r_min0 == r_top0) begin
                            n_mcount = r_mcount - 1'b1;
                            n_min0   = r_min1;
                            n_min1   = w_min_rd_data;
                        end
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end

        // report the state after the operation
        n_res.top_value = (n_count != '0) ? n_top0 : '0;
        n_res.min_value = (n_count != '0 && n_mcount != '0) ? n_min0 : -32'sd1;
        n_res.depth     = DEPTH_W'(n_count);
        n_res.is_empty  = (n_count == '0);

        // third entry from the top, as seen after this cycle
        w_val_rd_addr = ADDR_W'(n_count - CNT_W'(3));
        w_min_rd_addr = ADDR_W'(n_mcount - CNT_W'(3));
    end

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_val_wr),
        .i_wr_addr (w_val_wr_addr),
        .i_wr_data (w_push_value),
        .i_rd_addr (w_val_rd_addr),
        .o_rd_data (w_val_rd_data)
    );

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_min_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_min_wr),
        .i_wr_addr (w_min_wr_addr),
        .i_wr_data (w_push_value),
        .i_rd_addr (w_min_rd_addr),
        .o_rd_data (w_min_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_mcount <= n_mcount;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // cached entries and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_top0 <= n_top0;
        r_top1 <= n_top1;
        r_min0 <= n_min0;
        r_min1 <= n_min1;
        if (w_accept) begin
            r_res    <= n_res;
            r_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_res;
    assign o_m_axis_tuser  = r_status;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("value count beyond stack depth");

    a_min_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcount <= r_count)
        else $error("minimum stack deeper than value stack");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_OVERFLOW |-> r_res.depth == DEPTH_W'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_UNDERFLOW |-> r_res.is_empty)
        else $error("underflow reported on a non-empty stack");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && t_opcode'(i_s_axis_tuser) == OP_POP && r_count != '0
        |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not reduce the count");

endmodule

// ===== verif/min_tracking_stack_unit_test.sv =====
`timescale 1ns / 100ps

module min_tracking_stack_unit_test;
    import mts_pkg::*;

    // expected content of one result beat
    typedef struct {
        t_result res;
        t_status st;
    } t_stack_answer;

    // Tracks the value stack and the running-minimum stack and queues the
    // answer each accepted op should produce.
    class stack_tracker;
        logic signed [DATA_W-1:0] values [STACK_DEPTH];
        logic signed [DATA_W-1:0] minima [STACK_DEPTH];
        int                       value_cnt;
        int                       min_cnt;
        t_stack_answer            answers [$];
        int                       errors;
        int                       n_results;

        function new();
            value_cnt = 0;
            min_cnt   = 0;
            errors    = 0;
            n_results = 0;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        // apply one op to the stack copy and queue what the block must answer
        function void note_op(t_opcode op, logic signed [DATA_W-1:0] x);
            t_stack_answer a;
            a.res.popped_value = '0;
            a.st               = ST_OK;
            if (op == OP_PUSH) begin
                if (value_cnt >= STACK_DEPTH) begin
                    // full: push dropped, minimum stack untouched
                    a.st = ST_OVERFLOW;
                end else begin
                    values[value_cnt] = x;
                    value_cnt++;
                    if (min_cnt == 0) begin
                        minima[0] = x;
                        min_cnt   = 1;
                    end else if (min_cnt < STACK_DEPTH && minima[min_cnt-1] >= x) begin
                        // ties go on again so duplicate minima survive a pop
                        minima[min_cnt] = x;
                        min_cnt++;
                    end
                end
            end else begin
                if (value_cnt == 0) begin
                    a.res.popped_value = -1;
                    a.st               = ST_UNDERFLOW;
                end else begin
                    value_cnt--;
                    a.res.popped_value = values[value_cnt];
                    if (min_cnt > 0 && minima[min_cnt-1] == values[value_cnt])
                        min_cnt--;
                end
            end
            a.res.top_value = (value_cnt > 0) ? values[value_cnt-1] : '0;
            a.res.min_value = (value_cnt > 0 && min_cnt > 0) ? minima[min_cnt-1] : -1;
            a.res.depth     = DEPTH_W'(value_cnt);
            a.res.is_empty  = (value_cnt == 0);
            answers.push_back(a);
        endfunction

        function void cmp_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one result beat against the oldest queued answer
        function void check_beat(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            t_result       got;
            t_stack_answer a;
            got = t_result'(tdata);
            n_results++;
            if (answers.size() == 0) begin
                $error("result beat with no op outstanding");
                errors++;
                return;
            end
            a = answers.pop_front();
            cmp_field("popped_value", a.res.popped_value, got.popped_value);
            cmp_field("top_value", a.res.top_value, got.top_value);
            cmp_field("min_value", a.res.min_value, got.min_value);
            cmp_field("depth", a.res.depth, got.depth);
            cmp_field("is_empty", a.res.is_empty, got.is_empty);
            cmp_field("status", a.st, tuser);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;    // [31:0] push_value
    logic [S_TUSER_W-1:0] i_s_axis_tuser;    // [0] opcode
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // [31:0] popped_value, [63:32] top_value, [95:64] min_value,
    // [102:96] depth, [103] is_empty
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [M_TUSER_W-1:0] o_m_axis_tuser;    // [1:0] status

    stack_tracker tracker;

    min_tracking_stack_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Gap length: mostly back to back, some short gaps, a few long ones.
    // calm forces a stretch with no idling at all.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Input value mix: full-range noise, a narrow band around zero so that
    // ties with the minimum are common, and the two extremes.
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        if (r < 8)
            return DATA_W'($signed($urandom_range(0, 16)) - 8);
        if (r == 8)
            return 32'h8000_0000;
        return 32'h7FFF_FFFF;
    endfunction

    // Monitors: everything sampled at the rising edge, inputs move on the
    // falling edge, so no same-step races.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            tracker.note_op(t_opcode'(i_s_axis_tuser), $signed(i_s_axis_tdata));
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_beat(o_m_axis_tdata, o_m_axis_tuser);
    end

    // Offer one op beat after an optional gap; returns once it is accepted.
    // tvalid stays high across back-to-back beats (one assignment per edge).
    task automatic send_op(t_opcode op, logic [DATA_W-1:0] val, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= val;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
    endtask

    // Result-side ready pattern. Once, after a couple hundred results, the
    // sink holds off for a long stretch so the stack backs up and stalls
    // the input side.
    task automatic drive_result_ready();
        int  gap;
        int  iter;
        bit  held;
        iter = 0;
        held = 1'b0;
        forever begin
            iter++;
            if (!held && tracker.n_results >= 200) begin
                held = 1'b1;
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat (159) @(negedge i_clk);
            end else begin
                gap = pick_gap(((iter / 150) % 3) == 0);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_m_axis_tready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
        end
    endtask

    initial begin
        int seg_pct;
        int wait_cnt;
        t_opcode op;

        tracker         = new();
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_PUSH;
        i_m_axis_tready = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            drive_result_ready();
        join_none

        // directed: underflow, extremes, duplicate minima, drain to empty
        send_op(OP_POP,  32'hFFFF_FFFF, 0);    // pop on empty
        send_op(OP_PUSH, 32'h0000_0000, 0);
        send_op(OP_PUSH, 32'h7FFF_FFFF, 0);
        send_op(OP_PUSH, 32'h8000_0000, 0);
        send_op(OP_PUSH, 32'h8000_0000, 1);    // tie with current minimum
        send_op(OP_PUSH, 32'hFFFF_FFFF, 0);
        send_op(OP_POP,  32'h0000_0000, 0);
        send_op(OP_POP,  32'h7FFF_FFFF, 0);    // one copy of min left
        send_op(OP_POP,  32'h8000_0000, 2);
        send_op(OP_POP,  32'h5555_5555, 0);
        send_op(OP_POP,  32'hAAAA_AAAA, 0);    // back to empty
        send_op(OP_POP,  32'h0000_0000, 0);    // underflow again
        send_op(OP_PUSH, 32'd5, 0);
        send_op(OP_PUSH, 32'd3, 0);
        send_op(OP_PUSH, 32'd3, 0);
        send_op(OP_PUSH, 32'd7, 0);
        send_op(OP_POP,  32'd0, 0);
        send_op(OP_POP,  32'd0, 0);
        send_op(OP_POP,  32'd0, 0);
        send_op(OP_POP,  32'd0, 0);
        send_op(OP_POP,  32'd0, 0);

        // random: 50-op segments with a varying push share; the first two
        // are push heavy so the stack fills and overflow pushes occur
        for (int i = 0; i < 950; i++) begin
            if (i % 50 == 0)
                seg_pct = (i < 100) ? 92 : $urandom_range(15, 90);
            op = ($urandom_range(0, 99) < seg_pct) ? OP_PUSH : OP_POP;
            send_op(op, (op == OP_PUSH) ? pick_value() : $urandom,
                    pick_gap(((i / 40) % 4) == 0));
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        // drain outstanding results, then a few idle cycles
        wait_cnt = 0;
        while (tracker.pending() != 0 && wait_cnt < 5000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (4) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            $error("%0d expected results never arrived", tracker.pending());
            tracker.errors++;
        end

        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
